[hdl/pfrr_pkg.sv]
`timescale 1ns / 1ps

package pfrr_pkg;

    localparam int PAGE_W  = 9;
    localparam int FRAME_W = 6;
    localparam int EVP_W   = 8;
    localparam int FCNT_W  = 7;
    localparam int PAGES_W = 9;
    localparam int WORD_W  = 16;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    // register indexes, byte address is 4 * index
    localparam logic [1:0] REG_PAGES  = 2'd0;
    localparam logic [1:0] REG_FRAMES = 2'd1;
    localparam logic [1:0] REG_PERIOD = 2'd2;
    localparam logic [1:0] REG_SEED   = 2'd3;

    localparam logic [PAGES_W-1:0] PAGES_RST  = 9'd256;
    localparam logic [FCNT_W-1:0]  FRAMES_RST = 7'd64;
    localparam logic [WORD_W-1:0]  PERIOD_RST = 16'd8;
    localparam logic [WORD_W-1:0]  SEED_RST   = 16'd44257;
    localparam logic [WORD_W-1:0]  LFSR_TAPS  = 16'hB400;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,
        OP_ACCEPT,
        OP_HIT,
        OP_ALLOC,
        OP_DRAW_START,
        OP_DRAW_NEXT,
        OP_DRAW_TAKE,
        OP_SCAN_START,
        OP_SCAN_NEXT,
        OP_SCAN_TAKE,
        OP_INSTALL,
        OP_SWEEP,
        OP_LOAD_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic init_last;
        logic bad;
        logic mapped;
        logic free_avail;
        logic victim_ok;
        logic draw_last;
        logic scan_last;
        logic sweep_done;
        logic clr;
    } status_t;

    typedef struct packed {
        logic [PAGES_W-1:0] pages;
        logic [FCNT_W-1:0]  frames;
        logic [WORD_W-1:0]  period;
    } cfg_t;

    typedef struct packed {
        logic               pool;
        logic               lfsr;
        logic [FCNT_W-1:0]  frames;
        logic [WORD_W-1:0]  seed;
    } cfg_load_t;

    function automatic logic [WORD_W-1:0] lfsr_step(input logic [WORD_W-1:0] v);
        lfsr_step = {1'b0, v[WORD_W-1:1]} ^ (v[0] ? LFSR_TAPS : '0);
    endfunction

    function automatic logic [WORD_W-1:0] seed_load(input logic [WORD_W-1:0] v);
        seed_load = (v == '0) ? WORD_W'(1) : v;
    endfunction

    // zero acts as one, above the frame limit acts as the limit
    function automatic logic [FCNT_W-1:0] eff_frames(input logic [FCNT_W-1:0] v,
                                                     input int maxf);
        logic [FCNT_W-1:0] m;
        m = FCNT_W'(maxf);
        if (v == '0)
            eff_frames = FCNT_W'(1);
        else if (v > m)
            eff_frames = m;
        else
            eff_frames = v;
    endfunction

endpackage

[hdl/pfrr_if.sv]
`timescale 1ns / 1ps

interface pfrr_in_if;
    logic                         valid;
    logic                         ready;
    logic [pfrr_pkg::PAGE_W-1:0]  page;
    logic                         is_write;

    modport source (output valid, page, is_write, input ready);
    modport sink   (input valid, page, is_write, output ready);
endinterface

interface pfrr_out_if;
    logic                         valid;
    logic                         ready;
    logic                         fault;
    logic [pfrr_pkg::FRAME_W-1:0] frame;
    logic                         evicted_valid;
    logic [pfrr_pkg::EVP_W-1:0]   evicted_page;
    logic                         evicted_dirty;
    logic                         bad_address;

    modport source (output valid, fault, frame, evicted_valid, evicted_page,
                    evicted_dirty, bad_address, input ready);
    modport sink   (input valid, fault, frame, evicted_valid, evicted_page,
                    evicted_dirty, bad_address, output ready);
endinterface

[hdl/pfrr_regs.sv]
`timescale 1ns / 1ps

module pfrr_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pfrr_pkg::APB_AW-1:0]   paddr,
    input  logic [pfrr_pkg::APB_DW-1:0]   pwdata,
    output logic [pfrr_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output pfrr_pkg::cfg_t                cfg,
    output pfrr_pkg::cfg_load_t           cfg_load
);

    logic [pfrr_pkg::PAGES_W-1:0] pages_reg;
    logic [pfrr_pkg::FCNT_W-1:0]  frames_reg;
    logic [pfrr_pkg::WORD_W-1:0]  period_reg;
    logic [pfrr_pkg::WORD_W-1:0]  seed_reg;
    logic                         wr_en;
    logic [1:0]                   idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pages_reg  <= pfrr_pkg::PAGES_RST;
            frames_reg <= pfrr_pkg::FRAMES_RST;
            period_reg <= pfrr_pkg::PERIOD_RST;
            seed_reg   <= pfrr_pkg::SEED_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                pfrr_pkg::REG_PAGES:  pages_reg  <= pwdata[pfrr_pkg::PAGES_W-1:0];
                pfrr_pkg::REG_FRAMES: frames_reg <= pwdata[pfrr_pkg::FCNT_W-1:0];
                pfrr_pkg::REG_PERIOD: period_reg <= pwdata[pfrr_pkg::WORD_W-1:0];
                pfrr_pkg::REG_SEED:   seed_reg   <= pwdata[pfrr_pkg::WORD_W-1:0];
                default:              pages_reg  <= pages_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            pfrr_pkg::REG_PAGES:  prdata = pfrr_pkg::APB_DW'(pages_reg);
            pfrr_pkg::REG_FRAMES: prdata = pfrr_pkg::APB_DW'(frames_reg);
            pfrr_pkg::REG_PERIOD: prdata = pfrr_pkg::APB_DW'(period_reg);
            pfrr_pkg::REG_SEED:   prdata = pfrr_pkg::APB_DW'(seed_reg);
            default:              prdata = '0;
        endcase
    end

    assign cfg.pages  = pages_reg;
    assign cfg.frames = frames_reg;
    assign cfg.period = period_reg;

    // writing frames reloads the free pool, writing the seed reloads the lfsr
    assign cfg_load.pool   = wr_en && (idx == pfrr_pkg::REG_FRAMES);
    assign cfg_load.lfsr   = wr_en && (idx == pfrr_pkg::REG_SEED);
    assign cfg_load.frames = pwdata[pfrr_pkg::FCNT_W-1:0];
    assign cfg_load.seed   = pwdata[pfrr_pkg::WORD_W-1:0];

endmodule

[hdl/pfrr_dp.sv]
`timescale 1ns / 1ps

module pfrr_dp #(
    parameter int MAX_PAGES  = 256,
    parameter int MAX_FRAMES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pfrr_pkg::cmd_t                cmd,
    output pfrr_pkg::status_t             status,
    input  pfrr_pkg::cfg_t                cfg,
    input  pfrr_pkg::cfg_load_t           cfg_load,
    input  logic [pfrr_pkg::PAGE_W-1:0]   req_page,
    input  logic                          req_is_write,
    output logic                          fault,
    output logic [pfrr_pkg::FRAME_W-1:0]  frame,
    output logic                          evicted_valid,
    output logic [pfrr_pkg::EVP_W-1:0]    evicted_page,
    output logic                          evicted_dirty,
    output logic                          bad_address
);

    localparam int IW    = $clog2(MAX_PAGES);
    localparam int DEPTH = 1 << IW;
    localparam int FW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int PCW   = ($clog2(MAX_PAGES + 1) > pfrr_pkg::PAGE_W) ?
                           $clog2(MAX_PAGES + 1) : pfrr_pkg::PAGE_W;
    localparam int CW    = pfrr_pkg::FCNT_W;
    localparam int WW    = pfrr_pkg::WORD_W;
    localparam int OFW   = pfrr_pkg::FRAME_W;
    localparam int EVW   = pfrr_pkg::EVP_W;
    localparam logic [PCW-1:0] MAX_PAGES_C = PCW'(MAX_PAGES);
    localparam logic [CW-1:0]  MAX_FR_C    = CW'(MAX_FRAMES);
    localparam logic [CW-1:0]  FREE_RST    =
        pfrr_pkg::eff_frames(pfrr_pkg::FRAMES_RST, MAX_FRAMES);
    localparam logic [CW-1:0]  NEXT_RST    = FREE_RST - CW'(1);

    typedef struct packed {
        logic [FW-1:0] frame;
        logic          mapped;
        logic          dirty;
        logic          referenced;
    } entry_t;

    entry_t         mem [DEPTH];
    entry_t         rd_data_reg;
    logic [IW-1:0]  rd_addr_reg;

    logic           rd_en;
    logic [IW-1:0]  rd_addr;
    logic           we;
    logic [IW-1:0]  wa;
    entry_t         wd;

    logic [IW-1:0]  init_cnt_reg;
    logic [IW:0]    sw_cnt_reg;
    logic [IW:0]    sw_dec;
    logic [WW-1:0]  access_reg;
    logic [CW-1:0]  free_count_reg;
    logic [CW-1:0]  next_free_reg;
    logic [WW-1:0]  lfsr_reg;
    logic [WW-1:0]  draw_cnt_reg;

    logic [IW-1:0]  page_reg;
    logic           wr_reg;
    logic           bad_reg;
    logic           clr_reg;
    logic           ok_reg;
    logic [FW-1:0]  frame_reg;
    logic           fault_reg;
    logic           ev_valid_reg;
    logic [IW-1:0]  ev_page_reg;
    logic           ev_dirty_reg;

    logic           out_fault_reg;
    logic [FW-1:0]  out_frame_reg;
    logic           out_ev_valid_reg;
    logic [IW-1:0]  out_ev_page_reg;
    logic           out_ev_dirty_reg;
    logic           out_bad_reg;

    logic [PCW-1:0] eff_pages;
    logic [CW-1:0]  eff_fr;
    logic [CW-1:0]  reload_fr;
    logic [WW-1:0]  period_eff;
    logic           bad_now;
    logic [WW:0]    cnt_inc;
    logic           clr_now;
    logic [WW-1:0]  lfsr1;
    logic [WW-1:0]  lfsr2;
    logic [IW-1:0]  cand1;
    logic [IW-1:0]  cand2;
    logic           ok1;
    logic           ok2;
    logic [CW-1:0]  alloc_sum;
    logic [CW-1:0]  alloc_f;

    assign eff_pages  = (PCW'(cfg.pages) > MAX_PAGES_C) ? MAX_PAGES_C : PCW'(cfg.pages);
    assign eff_fr     = pfrr_pkg::eff_frames(cfg.frames, MAX_FRAMES);
    assign reload_fr  = pfrr_pkg::eff_frames(cfg_load.frames, MAX_FRAMES);
    assign period_eff = (cfg.period == '0) ? WW'(1) : cfg.period;
    assign bad_now    = PCW'(req_page) >= eff_pages;
    assign cnt_inc    = {1'b0, access_reg} + (WW + 1)'(1);
    assign clr_now    = cnt_inc >= {1'b0, period_eff};

    // candidate for the draw being issued and for the one after it
    assign lfsr1 = pfrr_pkg::lfsr_step(lfsr_reg);
    assign lfsr2 = pfrr_pkg::lfsr_step(lfsr1);
    assign cand1 = IW'(lfsr1);
    assign cand2 = IW'(lfsr2);
    assign ok1   = PCW'(cand1) < eff_pages;
    assign ok2   = PCW'(cand2) < eff_pages;

    // stale pointer wraps to frame zero
    assign alloc_sum = next_free_reg + CW'(1);
    assign alloc_f   = (alloc_sum >= eff_fr) ? '0 : alloc_sum;
    assign sw_dec    = sw_cnt_reg - (IW + 1)'(1);

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        we      = 1'b0;
        wa      = '0;
        wd      = '0;
        case (cmd.op)
            pfrr_pkg::OP_INIT:
            begin
                we = 1'b1;
                wa = init_cnt_reg;
            end
            pfrr_pkg::OP_ACCEPT:
            begin
                rd_en   = 1'b1;
                rd_addr = IW'(req_page);
            end
            pfrr_pkg::OP_HIT:
            begin
                we            = 1'b1;
                wa            = page_reg;
                wd.frame      = rd_data_reg.frame;
                wd.mapped     = 1'b1;
                wd.dirty      = rd_data_reg.dirty | wr_reg;
                wd.referenced = 1'b1;
            end
            pfrr_pkg::OP_DRAW_START:
            begin
                rd_en   = 1'b1;
                rd_addr = cand1;
            end
            pfrr_pkg::OP_DRAW_NEXT:
            begin
                rd_en   = 1'b1;
                rd_addr = cand2;
            end
            pfrr_pkg::OP_DRAW_TAKE, pfrr_pkg::OP_SCAN_TAKE:
            begin
                we = 1'b1;
                wa = rd_addr_reg;
            end
            pfrr_pkg::OP_SCAN_START:
            begin
                rd_en = 1'b1;
            end
            pfrr_pkg::OP_SCAN_NEXT:
            begin
                rd_en   = 1'b1;
                rd_addr = rd_addr_reg + IW'(1);
            end
            pfrr_pkg::OP_INSTALL:
            begin
                we            = 1'b1;
                wa            = page_reg;
                wd.frame      = frame_reg;
                wd.mapped     = 1'b1;
                wd.dirty      = wr_reg;
                wd.referenced = 1'b1;
            end
            pfrr_pkg::OP_SWEEP:
            begin
                // read entry n while writing back entry n-1 with its bit cleared
                rd_en         = !sw_cnt_reg[IW];
                rd_addr       = sw_cnt_reg[IW-1:0];
                we            = (sw_cnt_reg != '0);
                wa            = sw_dec[IW-1:0];
                wd            = rd_data_reg;
                wd.referenced = 1'b0;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_cnt_reg   <= '0;
            sw_cnt_reg     <= '0;
            access_reg     <= '0;
            free_count_reg <= FREE_RST;
            next_free_reg  <= NEXT_RST;
            lfsr_reg       <= pfrr_pkg::SEED_RST;
            draw_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_load.pool)
            begin
                free_count_reg <= reload_fr;
                next_free_reg  <= reload_fr - CW'(1);
            end
            if (cfg_load.lfsr)
            begin
                lfsr_reg <= pfrr_pkg::seed_load(cfg_load.seed);
            end
            case (cmd.op)
                pfrr_pkg::OP_INIT:
                begin
                    init_cnt_reg <= init_cnt_reg + IW'(1);
                end
                pfrr_pkg::OP_ACCEPT:
                begin
                    sw_cnt_reg <= '0;
                    if (!bad_now)
                    begin
                        access_reg <= clr_now ? '0 : cnt_inc[WW-1:0];
                    end
                end
                pfrr_pkg::OP_ALLOC:
                begin
                    next_free_reg  <= alloc_f;
                    free_count_reg <= free_count_reg - CW'(1);
                end
                pfrr_pkg::OP_DRAW_START:
                begin
                    draw_cnt_reg <= WW'(1);
                end
                pfrr_pkg::OP_DRAW_NEXT:
                begin
                    lfsr_reg     <= lfsr1;
                    draw_cnt_reg <= draw_cnt_reg + WW'(1);
                end
                pfrr_pkg::OP_DRAW_TAKE, pfrr_pkg::OP_SCAN_START:
                begin
                    lfsr_reg <= lfsr1;
                end
                pfrr_pkg::OP_SWEEP:
                begin
                    sw_cnt_reg <= sw_cnt_reg + (IW + 1)'(1);
                end
                default:
                begin
                    draw_cnt_reg <= draw_cnt_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            pfrr_pkg::OP_ACCEPT:
            begin
                page_reg     <= IW'(req_page);
                wr_reg       <= req_is_write;
                bad_reg      <= bad_now;
                clr_reg      <= clr_now;
                frame_reg    <= '0;
                fault_reg    <= 1'b0;
                ev_valid_reg <= 1'b0;
                ev_page_reg  <= '0;
                ev_dirty_reg <= 1'b0;
            end
            pfrr_pkg::OP_HIT:
            begin
                frame_reg <= rd_data_reg.frame;
            end
            pfrr_pkg::OP_ALLOC:
            begin
                frame_reg <= FW'(alloc_f);
            end
            pfrr_pkg::OP_DRAW_START:
            begin
                ok_reg <= ok1;
            end
            pfrr_pkg::OP_DRAW_NEXT:
            begin
                ok_reg <= ok2;
            end
            pfrr_pkg::OP_DRAW_TAKE, pfrr_pkg::OP_SCAN_TAKE:
            begin
                frame_reg    <= rd_data_reg.frame;
                ev_valid_reg <= 1'b1;
                ev_page_reg  <= rd_addr_reg;
                ev_dirty_reg <= rd_data_reg.dirty;
            end
            pfrr_pkg::OP_INSTALL:
            begin
                fault_reg <= 1'b1;
            end
            pfrr_pkg::OP_LOAD_OUT:
            begin
                out_fault_reg    <= fault_reg;
                out_frame_reg    <= frame_reg;
                out_ev_valid_reg <= ev_valid_reg;
                out_ev_page_reg  <= ev_page_reg;
                out_ev_dirty_reg <= ev_dirty_reg;
                out_bad_reg      <= bad_reg;
            end
            default:
            begin
                ok_reg <= ok_reg;
            end
        endcase
    end

    assign status.init_last  = (init_cnt_reg == '1);
    assign status.bad        = bad_reg;
    assign status.mapped     = rd_data_reg.mapped;
    assign status.free_avail = (free_count_reg != '0);
    assign status.victim_ok  = ok_reg && rd_data_reg.mapped;
    assign status.draw_last  = (draw_cnt_reg == '1);
    assign status.scan_last  = (rd_addr_reg == '1);
    assign status.sweep_done = sw_cnt_reg[IW];
    assign status.clr        = clr_reg;

    assign fault         = out_fault_reg;
    assign frame         = OFW'(out_frame_reg);
    assign evicted_valid = out_ev_valid_reg;
    assign evicted_page  = EVW'(out_ev_page_reg);
    assign evicted_dirty = out_ev_dirty_reg;
    assign bad_address   = out_bad_reg;

`ifndef ASSERT_OFF
    a_install_not_bad: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == pfrr_pkg::OP_INSTALL) |-> !bad_reg)
        else $error("out-of-range page installed into the table");

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= MAX_FR_C)
        else $error("free frame count above frame limit");
`endif

endmodule

[hdl/pfrr_ctrl.sv]
`timescale 1ns / 1ps

module pfrr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output pfrr_pkg::cmd_t    cmd,
    input  pfrr_pkg::status_t status
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_LOOK,
        ST_CHECK,
        ST_SCAN,
        ST_INSTALL,
        ST_SWEEP,
        ST_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = pfrr_pkg::OP_NONE;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.op = pfrr_pkg::OP_INIT;
                if (status.init_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.op     = pfrr_pkg::OP_ACCEPT;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (status.bad)
                    state_next = ST_RESULT;
                else if (status.mapped)
                begin
                    cmd.op     = pfrr_pkg::OP_HIT;
                    state_next = ST_RESULT;
                end
                else if (status.free_avail)
                begin
                    cmd.op     = pfrr_pkg::OP_ALLOC;
                    state_next = ST_INSTALL;
                end
                else
                begin
                    cmd.op     = pfrr_pkg::OP_DRAW_START;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.victim_ok)
                begin
                    cmd.op     = pfrr_pkg::OP_DRAW_TAKE;
                    state_next = ST_INSTALL;
                end
                else if (status.draw_last)
                begin
                    // random draws used up, fall back to the lowest mapped page
                    cmd.op     = pfrr_pkg::OP_SCAN_START;
                    state_next = ST_SCAN;
                end
                else
                    cmd.op = pfrr_pkg::OP_DRAW_NEXT;
            end
            ST_SCAN:
            begin
                if (status.mapped)
                begin
                    cmd.op     = pfrr_pkg::OP_SCAN_TAKE;
                    state_next = ST_INSTALL;
                end
                else if (status.scan_last)
                    state_next = ST_INSTALL;
                else
                    cmd.op = pfrr_pkg::OP_SCAN_NEXT;
            end
            ST_INSTALL:
            begin
                cmd.op     = pfrr_pkg::OP_INSTALL;
                state_next = status.clr ? ST_SWEEP : ST_RESULT;
            end
            ST_SWEEP:
            begin
                cmd.op = pfrr_pkg::OP_SWEEP;
                if (status.sweep_done)
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.op     = pfrr_pkg::OP_LOAD_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.op == pfrr_pkg::OP_LOAD_OUT)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_check_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |->
            ($past(state_reg) == ST_LOOK || $past(state_reg) == ST_CHECK))
        else $error("victim check entered from an unexpected state");

    a_sweep_clr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> status.clr)
        else $error("reference sweep without a clear period hit");
`endif

endmodule

[hdl/page_fault_random_replacement.sv]
`timescale 1ns / 1ps

// Page table with random replacement, one access item in, one result item out.
// req carries page and is_write; rsp carries fault, frame, evicted_valid,
// evicted_page, evicted_dirty and bad_address. Registers are written over APB
// at byte address 4*index (pages_in_use, frames_in_use, clear_period,
// lfsr_seed), by the user only while idle; the block does not enforce this.
// One item is worked at a time; the entry table is a single-port-write,
// single-port-read memory. Steps from accept to result register:
//   out-of-range page or hit: lookup, then result
//   fault with a free frame:  lookup, frame allocation, install, result
//   fault with eviction:      lookup, random draws, after 65535 failed draws
//                             a linear scan of up to N entries, then install
//   a fault on a clear-period access adds a sweep to clear referenced bits
// where N is MAX_PAGES rounded up to a power of two.
// After reset a clearing pass writes all N entries while req.ready stays low;
// config writes are still taken during it.
// The result sits in an output register; a new item is accepted while it
// waits, and the block holds its next result until rsp.ready frees the slot.
module page_fault_random_replacement #(
    parameter int MAX_PAGES  = 256,
    parameter int MAX_FRAMES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    pfrr_in_if.sink                       req,
    pfrr_out_if.source                    rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pfrr_pkg::APB_AW-1:0]   paddr,
    input  logic [pfrr_pkg::APB_DW-1:0]   pwdata,
    output logic [pfrr_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    pfrr_pkg::cfg_t      cfg;
    pfrr_pkg::cfg_load_t cfg_load;
    pfrr_pkg::cmd_t      cmd;
    pfrr_pkg::status_t   status;

    pfrr_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cfg      (cfg),
        .cfg_load (cfg_load)
    );

    pfrr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .status    (status)
    );

    pfrr_dp #(
        .MAX_PAGES  (MAX_PAGES),
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg           (cfg),
        .cfg_load      (cfg_load),
        .req_page      (req.page),
        .req_is_write  (req.is_write),
        .fault         (rsp.fault),
        .frame         (rsp.frame),
        .evicted_valid (rsp.evicted_valid),
        .evicted_page  (rsp.evicted_page),
        .evicted_dirty (rsp.evicted_dirty),
        .bad_address   (rsp.bad_address)
    );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int PAGE_COUNT   = 256;
    localparam int FRAME_COUNT  = 64;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 11;
    localparam int SETTLE       = 4;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int SCRIPT_LEN   = 24;

    localparam logic [1:0] REG_PAGES  = pfrr_pkg::REG_PAGES;
    localparam logic [1:0] REG_FRAMES = pfrr_pkg::REG_FRAMES;
    localparam logic [1:0] REG_PERIOD = pfrr_pkg::REG_PERIOD;
    localparam logic [1:0] REG_SEED   = pfrr_pkg::REG_SEED;

    typedef enum int { IDLE_RECV_HEAVY, IDLE_SEND_HEAVY, IDLE_NONE } idle_mode_t;

    typedef struct packed {
        logic                         fault;
        logic [pfrr_pkg::FRAME_W-1:0] frame;
        logic                         evicted_valid;
        logic [pfrr_pkg::EVP_W-1:0]   evicted_page;
        logic                         evicted_dirty;
        logic                         bad_address;
    } translation_t;

    typedef struct packed {
        bit                          is_cfg;
        logic [1:0]                  reg_idx;
        logic [15:0]                 value;
        logic [pfrr_pkg::PAGE_W-1:0] page;
        logic                        is_write;
        bit                          typed;
        translation_t                want;
    } script_step_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [pfrr_pkg::APB_AW-1:0] paddr;
    logic [pfrr_pkg::APB_DW-1:0] pwdata;
    logic [pfrr_pkg::APB_DW-1:0] prdata;
    logic pready;

    pfrr_in_if  acc_if ();
    pfrr_out_if res_if ();

    page_fault_random_replacement #(
        .MAX_PAGES  (PAGE_COUNT),
        .MAX_FRAMES (FRAME_COUNT)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (acc_if),
        .rsp     (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // page table mirror; referenced bits never reach an output, so they are not kept
    logic [pfrr_pkg::FRAME_W-1:0] tbl_frame  [PAGE_COUNT];
    bit                           tbl_mapped [PAGE_COUNT];
    bit                           tbl_dirty  [PAGE_COUNT];
    int unsigned        cfg_pages, cfg_frames, cfg_period, cfg_seed;
    int unsigned        free_frames, last_frame, access_ctr;
    logic [15:0]        lfsr_state;

    translation_t expected_translations [$];
    int           failures = 0;
    int           cycle_count;
    bit           hold_off_pending = 1'b0;
    idle_mode_t   idle_mode = IDLE_RECV_HEAVY;

    //  cfg   register    value    page    wr    typed  fault frame  evv  evpage  evd  bad
    script_step_t access_script [SCRIPT_LEN] = '{
        '{1'b0, REG_PAGES,  16'd0,   9'd255, 1'b1, 1'b1, '{1'b1, 6'd0, 1'b0, 8'd0, 1'b0, 1'b0}},
        '{1'b0, REG_PAGES,  16'd0,   9'd255, 1'b0, 1'b1, '{1'b0, 6'd0, 1'b0, 8'd0, 1'b0, 1'b0}},
        '{1'b0, REG_PAGES,  16'd0,   9'd256, 1'b0, 1'b1, '{1'b0, 6'd0, 1'b0, 8'd0, 1'b0, 1'b1}},
        '{1'b0, REG_PAGES,  16'd0,   9'd511, 1'b1, 1'b1, '{1'b0, 6'd0, 1'b0, 8'd0, 1'b0, 1'b1}},
        '{1'b0, REG_PAGES,  16'd0,   9'd3,   1'b1, 1'b1, '{1'b1, 6'd1, 1'b0, 8'd0, 1'b0, 1'b0}},
        '{1'b0, REG_PAGES,  16'd0,   9'd128, 1'b0, 1'b1, '{1'b1, 6'd2, 1'b0, 8'd0, 1'b0, 1'b0}},
        '{1'b0, REG_PAGES,  16'd0,   9'd3,   1'b0, 1'b1, '{1'b0, 6'd1, 1'b0, 8'd0, 1'b0, 1'b0}},
        '{1'b0, REG_PAGES,  16'd0,   9'd170, 1'b1, 1'b1, '{1'b1, 6'd3, 1'b0, 8'd0, 1'b0, 1'b0}},
        '{1'b0, REG_PAGES,  16'd0,   9'd85,  1'b0, 1'b1, '{1'b1, 6'd4, 1'b0, 8'd0, 1'b0, 1'b0}},
        // eighth in-range access faults and clears referenced bits
        '{1'b0, REG_PAGES,  16'd0,   9'd200, 1'b0, 1'b1, '{1'b1, 6'd5, 1'b0, 8'd0, 1'b0, 1'b0}},
        '{1'b1, REG_FRAMES, 16'd1,   9'd0,   1'b0, 1'b0, '0},
        // pool reloaded, frame 0 handed out a second time
        '{1'b0, REG_PAGES,  16'd0,   9'd254, 1'b1, 1'b1, '{1'b1, 6'd0, 1'b0, 8'd0, 1'b0, 1'b0}},
        '{1'b1, REG_PAGES,  16'd1,   9'd0,   1'b0, 1'b0, '0},
        // no mapped page in range: every draw fails, lowest mapped page goes
        '{1'b0, REG_PAGES,  16'd0,   9'd0,   1'b0, 1'b1, '{1'b1, 6'd1, 1'b1, 8'd3, 1'b1, 1'b0}},
        '{1'b0, REG_PAGES,  16'd0,   9'd1,   1'b1, 1'b1, '{1'b0, 6'd0, 1'b0, 8'd0, 1'b0, 1'b1}},
        '{1'b0, REG_PAGES,  16'd0,   9'd0,   1'b1, 1'b1, '{1'b0, 6'd1, 1'b0, 8'd0, 1'b0, 1'b0}},
        '{1'b1, REG_PAGES,  16'd256, 9'd0,   1'b0, 1'b0, '0},
        '{1'b1, REG_FRAMES, 16'd2,   9'd0,   1'b0, 1'b0, '0},
        '{1'b0, REG_PAGES,  16'd0,   9'd10,  1'b0, 1'b1, '{1'b1, 6'd0, 1'b0, 8'd0, 1'b0, 1'b0}},
        '{1'b0, REG_PAGES,  16'd0,   9'd11,  1'b1, 1'b1, '{1'b1, 6'd1, 1'b0, 8'd0, 1'b0, 1'b0}},
        '{1'b0, REG_PAGES,  16'd0,   9'd12,  1'b0, 1'b0, '0},
        '{1'b0, REG_PAGES,  16'd0,   9'd13,  1'b1, 1'b0, '0},
        '{1'b0, REG_PAGES,  16'd0,   9'd255, 1'b0, 1'b0, '0},
        '{1'b0, REG_PAGES,  16'd0,   9'd11,  1'b0, 1'b0, '0}
    };

    function automatic int unsigned pages_limit();
        return (cfg_pages > PAGE_COUNT) ? PAGE_COUNT : cfg_pages;
    endfunction

    function automatic int unsigned frames_limit();
        if (cfg_frames == 0)
            return 1;
        return (cfg_frames > FRAME_COUNT) ? FRAME_COUNT : cfg_frames;
    endfunction

    function automatic void refill_frames();
        free_frames = frames_limit();
        last_frame  = frames_limit() - 1;
    endfunction

    function automatic void load_seed();
        lfsr_state = (cfg_seed == 0) ? 16'd1 : cfg_seed[15:0];
    endfunction

    function automatic void reset_table();
        foreach (tbl_mapped[i])
        begin
            tbl_frame[i]  = '0;
            tbl_mapped[i] = 1'b0;
            tbl_dirty[i]  = 1'b0;
        end
        cfg_pages  = 32'(pfrr_pkg::PAGES_RST);
        cfg_frames = 32'(pfrr_pkg::FRAMES_RST);
        cfg_period = 32'(pfrr_pkg::PERIOD_RST);
        cfg_seed   = 32'(pfrr_pkg::SEED_RST);
        access_ctr = 0;
        refill_frames();
        load_seed();
    endfunction

    function automatic logic [31:0] register_mask(input logic [1:0] idx);
        case (idx)
            REG_PAGES:  return 32'h1FF;
            REG_FRAMES: return 32'h7F;
            default:    return 32'hFFFF;
        endcase
    endfunction

    function automatic void apply_register(input logic [1:0] idx, input logic [31:0] value);
        case (idx)
            REG_PAGES:  cfg_pages = 32'(value[8:0]);
            REG_FRAMES:
            begin
                cfg_frames = 32'(value[6:0]);
                refill_frames();
            end
            REG_PERIOD: cfg_period = 32'(value[15:0]);
            REG_SEED:
            begin
                cfg_seed = 32'(value[15:0]);
                load_seed();
            end
            default:    cfg_pages = cfg_pages;
        endcase
    endfunction

    // galois step, candidate is the low byte; falls back to the lowest mapped page
    function automatic int choose_victim();
        int unsigned lim;
        logic [7:0]  cand;
        lim = pages_limit();
        for (int n = 0; n < 65535; n++)
        begin
            lfsr_state = {1'b0, lfsr_state[15:1]} ^
                         (lfsr_state[0] ? pfrr_pkg::LFSR_TAPS : 16'h0);
            cand = lfsr_state[7:0];
            if (32'(cand) < lim && tbl_mapped[cand])
                return int'(cand);
        end
        for (int n = 0; n < PAGE_COUNT; n++)
            if (tbl_mapped[n])
                return n;
        return -1;
    endfunction

    function automatic translation_t translate_access(input logic [pfrr_pkg::PAGE_W-1:0] page,
                                                      input logic wr);
        translation_t res;
        int unsigned  nxt, period, f;
        bit           clr;
        int           victim;
        logic [7:0]   idx;
        res = '0;
        if (32'(page) >= pages_limit())
        begin
            res.bad_address = 1'b1;
            return res;
        end
        idx    = page[7:0];
        period = (cfg_period == 0) ? 1 : cfg_period;
        nxt    = access_ctr + 1;
        clr    = nxt >= period;
        access_ctr = clr ? 0 : (nxt & 32'hFFFF);
        if (tbl_mapped[idx])
        begin
            if (wr)
                tbl_dirty[idx] = 1'b1;
            res.frame = tbl_frame[idx];
            return res;
        end
        if (free_frames > 0)
        begin
            f = last_frame + 1;
            if (f >= frames_limit())
                f = 0;
            last_frame = f;
            free_frames--;
            res.frame = f[pfrr_pkg::FRAME_W-1:0];
        end
        else
        begin
            victim = choose_victim();
            if (victim >= 0)
            begin
                res.frame          = tbl_frame[victim];
                res.evicted_valid  = 1'b1;
                res.evicted_page   = victim[pfrr_pkg::EVP_W-1:0];
                res.evicted_dirty  = tbl_dirty[victim];
                tbl_mapped[victim] = 1'b0;
                tbl_dirty[victim]  = 1'b0;
            end
        end
        tbl_frame[idx]  = res.frame;
        tbl_mapped[idx] = 1'b1;
        tbl_dirty[idx]  = wr;
        res.fault       = 1'b1;
        return res;
    endfunction

    function automatic bit roll(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic bit sender_idles();
        case (idle_mode)
            IDLE_RECV_HEAVY: return roll(38);
            IDLE_SEND_HEAVY: return roll(79);
            default:         return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_idles();
        case (idle_mode)
            IDLE_RECV_HEAVY: return roll(79);
            IDLE_SEND_HEAVY: return roll(38);
            default:         return 1'b0;
        endcase
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_access(input logic [pfrr_pkg::PAGE_W-1:0] page, input logic wr,
                               input bit typed, input translation_t want);
        translation_t predicted;
        while (sender_idles())
        begin
            acc_if.valid <= 1'b0;
            @(negedge clk);
        end
        acc_if.valid    <= 1'b1;
        acc_if.page     <= page;
        acc_if.is_write <= wr;
        do
            @(posedge clk);
        while (!acc_if.ready);
        predicted = translate_access(page, wr);
        expected_translations.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic drain_results();
        acc_if.valid <= 1'b0;
        while (expected_translations.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
    endtask

    // write, then read back over the same port
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] got;
        drain_results();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        apply_register(idx, value);
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        check_field("prdata", value & register_mask(idx), got);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic setup_phase(input int unsigned pages, input int unsigned frames,
                               input int unsigned period, input int unsigned seed);
        write_register(REG_PAGES, pages);
        write_register(REG_FRAMES, frames);
        write_register(REG_PERIOD, period);
        write_register(REG_SEED, seed);
    endtask

    // mostly in-range pages, a hot quarter for hits, some bad addresses
    task automatic run_phase(input int count, input idle_mode_t mode, input bit pressure);
        logic [pfrr_pkg::PAGE_W-1:0] page;
        int unsigned                 lim, r;
        idle_mode = mode;
        for (int i = 0; i < count; i++)
        begin
            lim = pages_limit();
            r   = $urandom_range(0, 99);
            if (r < 8)
                page = pfrr_pkg::PAGE_W'($urandom_range(lim, 511));
            else if (r < 12)
                page = pfrr_pkg::PAGE_W'($urandom_range(0, 511));
            else if (r < 50 && lim > 8)
                page = pfrr_pkg::PAGE_W'($urandom_range(0, lim / 4));
            else
                page = pfrr_pkg::PAGE_W'($urandom_range(0, lim - 1));
            if (pressure && i == count / 3)
                hold_off_pending = 1'b1;
            if (pressure && i == 2 * count / 3)
                drain_results();
            send_access(page, 1'($urandom_range(0, 1)), 1'b0, '0);
        end
    endtask

    initial
    begin : receiver
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_pending)
            begin
                // long stall so the block backs up into its input
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off_pending = 1'b0;
            end
            res_if.ready <= !receiver_idles();
        end
    end

    always @(posedge clk)
    begin : result_check
        translation_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (expected_translations.size() == 0)
            begin
                $error("result item with nothing expected");
                failures++;
            end
            else
            begin
                want = expected_translations.pop_front();
                check_field("fault", 32'(want.fault), 32'(res_if.fault));
                check_field("frame", 32'(want.frame), 32'(res_if.frame));
                check_field("evicted_valid", 32'(want.evicted_valid),
                            32'(res_if.evicted_valid));
                check_field("evicted_page", 32'(want.evicted_page),
                            32'(res_if.evicted_page));
                check_field("evicted_dirty", 32'(want.evicted_dirty),
                            32'(res_if.evicted_dirty));
                check_field("bad_address", 32'(want.bad_address),
                            32'(res_if.bad_address));
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        acc_if.valid    = 1'b0;
        acc_if.page     = '0;
        acc_if.is_write = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        rst_n   = 1'b0;
        reset_table();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        idle_mode = IDLE_RECV_HEAVY;
        foreach (access_script[i])
        begin
            if (access_script[i].is_cfg)
                write_register(access_script[i].reg_idx, 32'(access_script[i].value));
            else
                send_access(access_script[i].page, access_script[i].is_write,
                            access_script[i].typed, access_script[i].want);
        end

        setup_phase(256, 64, 8, 44257);
        run_phase(110, IDLE_RECV_HEAVY, 1'b0);
        setup_phase(16, 4, 3, 0);
        run_phase(120, IDLE_RECV_HEAVY, 1'b0);
        setup_phase(511, 127, 65535, 65535);
        run_phase(110, IDLE_SEND_HEAVY, 1'b0);
        setup_phase(1, 0, 0, 1);
        run_phase(60, IDLE_SEND_HEAVY, 1'b0);
        setup_phase(64, 8, 5, $urandom_range(1, 65535));
        run_phase(150, IDLE_NONE, 1'b1);
        setup_phase(200, 32, 1, $urandom_range(1, 65535));
        run_phase(120, IDLE_NONE, 1'b0);
        setup_phase(32, 16, 16, $urandom_range(1, 65535));
        run_phase(180, IDLE_NONE, 1'b0);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[sim.f]
hdl/pfrr_pkg.sv
hdl/pfrr_if.sv
hdl/pfrr_regs.sv
hdl/pfrr_dp.sv
hdl/pfrr_ctrl.sv
hdl/page_fault_random_replacement.sv
tb/testbench.sv
